// ----- sv/rv32s_pkg.sv -----
// shared constants, instruction codes and a helper function of the rv32i subset step core
`default_nettype none

package rv32s_pkg;

  localparam int XLEN              = 32;
  localparam int NUM_REGS          = 32;
  localparam int REG_AW            = 5;
  localparam int PC_OUT_W          = 10;
  localparam int MADDR_W           = 10;
  localparam int PLEN_W            = 11;
  localparam int DATA_WORDS_DEF    = 1024;
  localparam int PROGRAM_WORDS_DEF = 1024;

  typedef logic [6:0] opcode_t;
  typedef logic [2:0] funct3_t;
  typedef logic [6:0] funct7_t;

  localparam opcode_t OP_IMM    = 7'b0010011;
  localparam opcode_t OP_REG    = 7'b0110011;
  localparam opcode_t OP_BRANCH = 7'b1100011;
  localparam opcode_t OP_LOAD   = 7'b0000011;
  localparam opcode_t OP_STORE  = 7'b0100011;
  localparam opcode_t OP_JAL    = 7'b1101111;

  localparam funct3_t F3_ADD  = 3'b000;
  localparam funct3_t F3_OR   = 3'b110;
  localparam funct3_t F3_AND  = 3'b111;
  localparam funct3_t F3_BEQ  = 3'b000;
  localparam funct3_t F3_BNE  = 3'b001;
  localparam funct3_t F3_BLT  = 3'b100;
  localparam funct3_t F3_WORD = 3'b010;

  localparam funct7_t F7_BASE = 7'b0000000;
  localparam funct7_t F7_SUB  = 7'b0100000;

  // signed divide by four, truncating toward zero
  function automatic logic signed [XLEN-1:0] div4_trunc(input logic signed [XLEN-1:0] v);
    logic signed [XLEN-1:0] biased;
    biased = v[XLEN-1] ? (v + 32'sd3) : v;
    return biased >>> 2;
  endfunction

endpackage

`default_nettype wire

// ----- sv/rv32s_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module rv32s_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire                              clk,
  input  wire                              we,
  input  wire  [$clog2(DEPTH)-1:0]         waddr,
  input  wire  [WIDTH-1:0]                 wdata,
  input  wire                              re,
  input  wire  [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/rv32i_subset_instruction_step_core.sv -----
// top level of the rv32i subset step core: decode, execute, register file and data memory
//
// Takes one instruction word per cycle while in_stall is low and returns one result per
// instruction, in order. An instruction goes through an operand stage (register file read)
// and then a result stage (data memory read), which offers its result; back-to-back
// instructions that depend on each other are served by forwarding, with no bubbles.
// After reset the data memory is cleared one word a cycle, with in_stall held high until
// the clearing is done; program_length may be written meanwhile. PROGRAM_WORDS must be a
// power of two; next_pc shows the low 10 bits of the pc.
`default_nettype none

module rv32i_subset_instruction_step_core #(
  parameter int DATA_WORDS    = rv32s_pkg::DATA_WORDS_DEF,
  parameter int PROGRAM_WORDS = rv32s_pkg::PROGRAM_WORDS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire  [31:0]                          in_instruction,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [rv32s_pkg::PLEN_W-1:0]         cfg_program_length,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [rv32s_pkg::PC_OUT_W-1:0]       out_next_pc,
  output logic                                 out_reg_written,
  output logic [rv32s_pkg::REG_AW-1:0]         out_reg_index,
  output logic signed [rv32s_pkg::XLEN-1:0]    out_reg_value,
  output logic                                 out_mem_written,
  output logic [rv32s_pkg::MADDR_W-1:0]        out_mem_address,
  output logic signed [rv32s_pkg::XLEN-1:0]    out_mem_value,
  output logic                                 out_illegal,
  output logic                                 out_address_fault,
  output logic                                 out_done_res
);

  import rv32s_pkg::*;

  localparam int DM_AW = $clog2(DATA_WORDS);
  localparam int PC_W  = $clog2(PROGRAM_WORDS);

  // control state
  logic              clr_busy_r;
  logic [DM_AW-1:0]  clr_addr_r;
  logic [PLEN_W-1:0] prog_len_r;
  logic [PC_W-1:0]   pc_r;
  logic [NUM_REGS-1:0] rf_vld_r;

  // operand stage
  logic              s1_valid_r;
  logic [31:0]       s1_ins_r;
  logic              a_fix_r, b_fix_r;
  logic [XLEN-1:0]   a_fixd_r, b_fixd_r;
  logic              a_vld_r, b_vld_r;

  // result stage
  logic              s2_valid_r;
  logic [PC_OUT_W-1:0] s2_npc_r;
  logic              s2_regw_r;
  logic [REG_AW-1:0] s2_rd_r;
  logic [XLEN-1:0]   s2_val_r;
  logic              s2_load_r;
  logic              s2_memw_r;
  logic [MADDR_W-1:0] s2_maddr_r;
  logic [XLEN-1:0]   s2_memval_r;
  logic              s2_ill_r;
  logic              s2_fault_r;
  logic              s2_done_r;

  logic [PC_OUT_W-1:0] s2_npc_nxt;
  logic              s2_regw_nxt;
  logic [REG_AW-1:0] s2_rd_nxt;
  logic [XLEN-1:0]   s2_val_nxt;
  logic              s2_load_nxt;
  logic              s2_memw_nxt;
  logic [MADDR_W-1:0] s2_maddr_nxt;
  logic [XLEN-1:0]   s2_memval_nxt;
  logic              s2_ill_nxt;
  logic              s2_fault_nxt;
  logic              s2_done_nxt;
  logic [PC_W-1:0]   pc_nxt;

  logic in_fire, out_fire, s2_free, s1_adv;

  logic [XLEN-1:0]   rfa_q, rfb_q, dm_q;
  logic              rf_we;
  logic [REG_AW-1:0] rf_waddr;
  logic [XLEN-1:0]   rf_wdata;
  logic [XLEN-1:0]   s2_wval;

  logic              dm_we, dm_re;
  logic [DM_AW-1:0]  dm_waddr;
  logic [XLEN-1:0]   dm_wdata;

  opcode_t           op;
  funct3_t           f3;
  funct7_t           f7;
  logic [REG_AW-1:0] rd, rs1, rs2;
  logic [XLEN-1:0]   opa, opb;
  logic signed [XLEN-1:0] imm_i, imm_s, imm_b, imm_j;
  logic signed [XLEN-1:0] off_ls, delta;
  logic [XLEN:0]     addr;
  logic              in_range;
  logic              wr, ld, st, memop, ill, fault;
  logic [XLEN-1:0]   wval;
  logic [XLEN-1:0]   target;
  logic [PC_W-1:0]   np;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = s2_valid_r && !out_stall;
  assign s2_free  = !s2_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && s2_free;
  assign in_stall = clr_busy_r || (s1_valid_r && !s2_free);
  assign cfg_ready = 1'b1;

  // register file write back at result departure
  assign s2_wval  = s2_load_r ? dm_q : s2_val_r;
  assign rf_we    = out_fire && s2_regw_r;
  assign rf_waddr = s2_rd_r;
  assign rf_wdata = s2_wval;

  rv32s_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_fire),
    .raddr (in_instruction[19:15]),
    .rdata (rfa_q)
  );

  rv32s_ram #(.WIDTH(XLEN), .DEPTH(NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (in_fire),
    .raddr (in_instruction[24:20]),
    .rdata (rfb_q)
  );

  // decode
  assign op  = s1_ins_r[6:0];
  assign f3  = s1_ins_r[14:12];
  assign f7  = s1_ins_r[31:25];
  assign rd  = s1_ins_r[11:7];
  assign rs1 = s1_ins_r[19:15];
  assign rs2 = s1_ins_r[24:20];

  // operands: forward from result stage, else late writes, else register file once written, else zero
  always_comb begin
    if (s2_valid_r && s2_regw_r && (s2_rd_r == rs1)) begin
      opa = s2_wval;
    end else if (a_fix_r) begin
      opa = a_fixd_r;
    end else if (a_vld_r) begin
      opa = rfa_q;
    end else begin
      opa = '0;
    end
    if (s2_valid_r && s2_regw_r && (s2_rd_r == rs2)) begin
      opb = s2_wval;
    end else if (b_fix_r) begin
      opb = b_fixd_r;
    end else if (b_vld_r) begin
      opb = rfb_q;
    end else begin
      opb = '0;
    end
  end

  assign imm_i = {{20{s1_ins_r[31]}}, s1_ins_r[31:20]};
  assign imm_s = {{20{s1_ins_r[31]}}, s1_ins_r[31:25], s1_ins_r[11:7]};
  assign imm_b = {{19{s1_ins_r[31]}}, s1_ins_r[31], s1_ins_r[7], s1_ins_r[30:25],
                  s1_ins_r[11:8], 1'b0};
  assign imm_j = {{12{s1_ins_r[31]}}, s1_ins_r[31:12]};

  assign off_ls   = div4_trunc((op == OP_STORE) ? imm_s : imm_i);
  assign addr     = {opa[XLEN-1], opa} + {off_ls[XLEN-1], off_ls};
  assign in_range = !addr[XLEN] && (addr[XLEN-1:0] < 32'(DATA_WORDS));

  always_comb begin
    wr    = 1'b0;
    ld    = 1'b0;
    st    = 1'b0;
    memop = 1'b0;
    ill   = 1'b0;
    fault = 1'b0;
    wval  = '0;
    delta = 32'sd1;
    unique case (op)
      OP_IMM: begin
        case (f3)
          F3_ADD: begin
            wr   = 1'b1;
            wval = opa + imm_i;
          end
          F3_OR: begin
            wr   = 1'b1;
            wval = opa | imm_i;
          end
          F3_AND: begin
            wr   = 1'b1;
            wval = opa & imm_i;
          end
          default: ill = 1'b1;
        endcase
      end
      OP_REG: begin
        if (f7 == F7_BASE && f3 == F3_ADD) begin
          wr   = 1'b1;
          wval = opa + opb;
        end else if (f7 == F7_BASE && f3 == F3_OR) begin
          wr   = 1'b1;
          wval = opa | opb;
        end else if (f7 == F7_BASE && f3 == F3_AND) begin
          wr   = 1'b1;
          wval = opa & opb;
        end else if (f7 == F7_SUB && f3 == F3_ADD) begin
          wr   = 1'b1;
          wval = opa - opb;
        end else begin
          ill = 1'b1;
        end
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ: if (opa == opb) delta = div4_trunc(imm_b);
          F3_BNE: if (opa != opb) delta = div4_trunc(imm_b);
          F3_BLT: if ($signed(opa) < $signed(opb)) delta = div4_trunc(imm_b);
          default: ill = 1'b1;
        endcase
      end
      OP_LOAD: begin
        if (f3 != F3_WORD) begin
          ill = 1'b1;
        end else begin
          memop = 1'b1;
          ld    = 1'b1;
          wr    = 1'b1;
          fault = !in_range;
        end
      end
      OP_STORE: begin
        if (f3 != F3_WORD) begin
          ill = 1'b1;
        end else begin
          memop = 1'b1;
          st    = 1'b1;
          fault = !in_range;
        end
      end
      OP_JAL: begin
        wr    = 1'b1;
        wval  = 32'(pc_r) + 32'd1;
        delta = div4_trunc(imm_j);
      end
      default: ill = 1'b1;
    endcase
  end

  assign target = 32'(pc_r) + delta;
  assign np     = target[PC_W-1:0];

  always_comb begin
    s2_regw_nxt   = wr && (rd != '0);
    s2_rd_nxt     = s2_regw_nxt ? rd : '0;
    s2_val_nxt    = (s2_regw_nxt && !ld) ? wval : '0;
    s2_load_nxt   = s2_regw_nxt && ld && !fault;
    s2_memw_nxt   = st && !fault;
    s2_memval_nxt = s2_memw_nxt ? opb : '0;
    s2_maddr_nxt  = memop ? addr[MADDR_W-1:0] : '0;
    s2_ill_nxt    = ill;
    s2_fault_nxt  = fault;
    s2_npc_nxt    = PC_OUT_W'(np);
    s2_done_nxt   = (target == 32'(prog_len_r)) || (32'(np) == 32'(prog_len_r));
    pc_nxt        = np;
  end

  // data memory, cleared after reset
  assign dm_we    = clr_busy_r || (s1_adv && s2_memw_nxt);
  assign dm_waddr = clr_busy_r ? clr_addr_r : addr[DM_AW-1:0];
  assign dm_wdata = clr_busy_r ? '0 : opb;
  assign dm_re    = s1_adv && s2_load_nxt;

  rv32s_ram #(.WIDTH(XLEN), .DEPTH(DATA_WORDS)) u_dmem (
    .clk   (clk),
    .we    (dm_we),
    .waddr (dm_waddr),
    .wdata (dm_wdata),
    .re    (dm_re),
    .raddr (addr[DM_AW-1:0]),
    .rdata (dm_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      prog_len_r <= '0;
      pc_r       <= '0;
      rf_vld_r   <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == DM_AW'(DATA_WORDS - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (cfg_valid && cfg_ready) begin
        prog_len_r <= cfg_program_length;
      end
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
      if (s1_adv) begin
        pc_r <= pc_nxt;
      end
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (out_fire) begin
        s2_valid_r <= 1'b0;
      end
    end
  end

  // operand stage payload, catching register writes that land after the read
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_ins_r <= in_instruction;
      a_vld_r  <= rf_vld_r[in_instruction[19:15]];
      b_vld_r  <= rf_vld_r[in_instruction[24:20]];
      a_fix_r  <= rf_we && (rf_waddr == in_instruction[19:15]);
      b_fix_r  <= rf_we && (rf_waddr == in_instruction[24:20]);
      a_fixd_r <= rf_wdata;
      b_fixd_r <= rf_wdata;
    end else begin
      if (rf_we && (rf_waddr == rs1)) begin
        a_fix_r  <= 1'b1;
        a_fixd_r <= rf_wdata;
      end
      if (rf_we && (rf_waddr == rs2)) begin
        b_fix_r  <= 1'b1;
        b_fixd_r <= rf_wdata;
      end
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_npc_r    <= s2_npc_nxt;
      s2_regw_r   <= s2_regw_nxt;
      s2_rd_r     <= s2_rd_nxt;
      s2_val_r    <= s2_val_nxt;
      s2_load_r   <= s2_load_nxt;
      s2_memw_r   <= s2_memw_nxt;
      s2_maddr_r  <= s2_maddr_nxt;
      s2_memval_r <= s2_memval_nxt;
      s2_ill_r    <= s2_ill_nxt;
      s2_fault_r  <= s2_fault_nxt;
      s2_done_r   <= s2_done_nxt;
    end
  end

  assign out_valid         = s2_valid_r;
  assign out_next_pc       = s2_npc_r;
  assign out_reg_written   = s2_regw_r;
  assign out_reg_index     = s2_rd_r;
  assign out_reg_value     = s2_wval;
  assign out_mem_written   = s2_memw_r;
  assign out_mem_address   = s2_maddr_r;
  assign out_mem_value     = s2_memval_r;
  assign out_illegal       = s2_ill_r;
  assign out_address_fault = s2_fault_r;
  assign out_done_res      = s2_done_r;

endmodule

`default_nettype wire

// ----- tb/rv32i_subset_instruction_step_core_tb.sv -----
// testbench of the rv32i subset step core: directed and random streams against a step predictor
`timescale 1ns / 1ps

module rv32i_subset_instruction_step_core_tb;
  import rv32s_pkg::*;

  localparam int DMEM_WORDS  = 1024;
  localparam int PMEM_WORDS  = 1024;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [PC_OUT_W-1:0] next_pc;
    logic                reg_written;
    logic [REG_AW-1:0]   reg_index;
    logic [XLEN-1:0]     reg_value;
    logic                mem_written;
    logic [MADDR_W-1:0]  mem_address;
    logic [XLEN-1:0]     mem_value;
    logic                illegal;
    logic                address_fault;
    logic                done_res;
  } step_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [31:0]           in_instruction;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [PLEN_W-1:0]     cfg_program_length;
  logic                  out_valid;
  logic                  out_stall;
  logic [PC_OUT_W-1:0]   out_next_pc;
  logic                  out_reg_written;
  logic [REG_AW-1:0]     out_reg_index;
  logic signed [XLEN-1:0] out_reg_value;
  logic                  out_mem_written;
  logic [MADDR_W-1:0]    out_mem_address;
  logic signed [XLEN-1:0] out_mem_value;
  logic                  out_illegal;
  logic                  out_address_fault;
  logic                  out_done_res;

  rv32i_subset_instruction_step_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_instruction     (in_instruction),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_program_length (cfg_program_length),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_next_pc        (out_next_pc),
    .out_reg_written    (out_reg_written),
    .out_reg_index      (out_reg_index),
    .out_reg_value      (out_reg_value),
    .out_mem_written    (out_mem_written),
    .out_mem_address    (out_mem_address),
    .out_mem_value      (out_mem_value),
    .out_illegal        (out_illegal),
    .out_address_fault  (out_address_fault),
    .out_done_res       (out_done_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  int             pc_model;
  logic [31:0]    regs_model [NUM_REGS];
  logic [31:0]    dmem_model [DMEM_WORDS];
  logic [10:0]    plen_model;
  step_result_t   expected_steps[$];
  int             error_count = 0;
  int             items_sent = 0;
  int             idle_pct = 27;
  int             cycle_count = 0;

  function automatic logic [31:0] enc_i(input opcode_t op, input funct3_t f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [11:0] imm);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_r(input funct7_t f7, input funct3_t f3,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [4:0] rs2);
    return {f7, rs2, rs1, f3, rd, OP_REG};
  endfunction

  function automatic logic [31:0] enc_s(input funct3_t f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [11:0] imm);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(input funct3_t f3, input logic [4:0] rs1,
                                        input logic [4:0] rs2, input logic [12:0] imm);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [19:0] imm);
    return {imm, rd, OP_JAL};
  endfunction

  function automatic step_result_t execute_step(input logic [31:0] ins);
    step_result_t r;
    opcode_t      op;
    funct3_t      f3;
    funct7_t      f7;
    logic [4:0]   rd;
    logic [31:0]  a, b, imm, wval;
    logic [12:0]  boff;
    logic [11:0]  soff;
    longint       off, addr, delta, target, np;
    logic         wr, memop, taken;
    r = '0;
    op = ins[6:0];
    f3 = ins[14:12];
    f7 = ins[31:25];
    rd = ins[11:7];
    a = regs_model[ins[19:15]];
    b = regs_model[ins[24:20]];
    imm = {{20{ins[31]}}, ins[31:20]};
    wr = 1'b0;
    memop = 1'b0;
    taken = 1'b0;
    wval = '0;
    delta = 1;
    addr = 0;
    case (op)
      OP_IMM: begin
        wr = 1'b1;
        if (f3 == F3_ADD) wval = a + imm;
        else if (f3 == F3_OR) wval = a | imm;
        else if (f3 == F3_AND) wval = a & imm;
        else begin
          wr = 1'b0;
          r.illegal = 1'b1;
        end
      end
      OP_REG: begin
        wr = 1'b1;
        if (f7 == F7_BASE && f3 == F3_ADD) wval = a + b;
        else if (f7 == F7_BASE && f3 == F3_OR) wval = a | b;
        else if (f7 == F7_BASE && f3 == F3_AND) wval = a & b;
        else if (f7 == F7_SUB && f3 == F3_ADD) wval = a - b;
        else begin
          wr = 1'b0;
          r.illegal = 1'b1;
        end
      end
      OP_BRANCH: begin
        boff = {ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        off = $signed(boff);
        off = off / 4;
        if (f3 == F3_BEQ) taken = (a == b);
        else if (f3 == F3_BNE) taken = (a != b);
        else if (f3 == F3_BLT) taken = ($signed(a) < $signed(b));
        else r.illegal = 1'b1;
        if (taken) delta = off;
      end
      OP_LOAD: begin
        if (f3 != F3_WORD) r.illegal = 1'b1;
        else begin
          off = $signed(ins[31:20]);
          off = off / 4;
          addr = $signed(a);
          addr = addr + off;
          memop = 1'b1;
          wr = 1'b1;
          if (addr >= 0 && addr < DMEM_WORDS) wval = dmem_model[addr[9:0]];
          else r.address_fault = 1'b1;
        end
      end
      OP_STORE: begin
        if (f3 != F3_WORD) r.illegal = 1'b1;
        else begin
          soff = {ins[31:25], ins[11:7]};
          off = $signed(soff);
          off = off / 4;
          addr = $signed(a);
          addr = addr + off;
          memop = 1'b1;
          if (addr >= 0 && addr < DMEM_WORDS) begin
            dmem_model[addr[9:0]] = b;
            r.mem_written = 1'b1;
            r.mem_value = b;
          end else begin
            r.address_fault = 1'b1;
          end
        end
      end
      OP_JAL: begin
        off = $signed(ins[31:12]);
        off = off / 4;
        wr = 1'b1;
        wval = pc_model + 1;
        delta = off;
      end
      default: r.illegal = 1'b1;
    endcase
    if (wr && rd != 5'd0) begin
      regs_model[rd] = wval;
      r.reg_written = 1'b1;
      r.reg_index = rd;
      r.reg_value = wval;
    end
    if (memop) r.mem_address = addr[9:0];
    target = longint'(pc_model) + delta;
    np = target % PMEM_WORDS;
    if (np < 0) np = np + PMEM_WORDS;
    pc_model = int'(np);
    r.next_pc = np[9:0];
    r.done_res = (target == longint'(plen_model)) || (np == longint'(plen_model));
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (actv !== expv) begin
      $error("%s: expected %0h, got %0h", name, expv, actv);
      error_count++;
    end
  endtask

  always @(posedge clk) begin : result_check
    step_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        $error("result with no pending request");
        error_count++;
      end else begin
        exp_r = expected_steps.pop_front();
        check_field("next_pc", exp_r.next_pc, out_next_pc);
        check_field("reg_written", exp_r.reg_written, out_reg_written);
        check_field("reg_index", exp_r.reg_index, out_reg_index);
        check_field("reg_value", exp_r.reg_value, out_reg_value);
        check_field("mem_written", exp_r.mem_written, out_mem_written);
        check_field("mem_address", exp_r.mem_address, out_mem_address);
        check_field("mem_value", exp_r.mem_value, out_mem_value);
        check_field("illegal", exp_r.illegal, out_illegal);
        check_field("address_fault", exp_r.address_fault, out_address_fault);
        check_field("done_res", exp_r.done_res, out_done_res);
      end
    end
    out_stall <= ($urandom_range(99) < idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_instr(input logic [31:0] ins);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_instruction <= ins;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_steps.insert(expected_steps.size(), execute_step(ins));
    items_sent++;
  endtask

  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_program_length(input logic [PLEN_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_program_length <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    plen_model = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic jump_to_pc(input int dest, input logic [4:0] rd);
    int d;
    d = dest - pc_model;
    send_instr(enc_j(rd, 20'(d * 4)));
  endtask

  function automatic logic [4:0] pick_reg();
    return $urandom_range(1) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
  endfunction

  function automatic funct3_t pick_alu_f3();
    case ($urandom_range(2))
      0: return F3_ADD;
      1: return F3_OR;
      default: return F3_AND;
    endcase
  endfunction

  task automatic test_immediate_ops();
    send_instr(enc_i(OP_IMM, F3_ADD, 5'd1, 5'd0, 12'h7FF));
    send_instr(enc_i(OP_IMM, F3_ADD, 5'd2, 5'd0, 12'h800));
    send_instr(enc_i(OP_IMM, F3_OR, 5'd3, 5'd2, 12'h0F0));
    // write to x0 is dropped
    send_instr(enc_i(OP_IMM, F3_AND, 5'd0, 5'd1, 12'hFFF));
  endtask

  task automatic test_register_ops();
    send_instr(enc_r(F7_BASE, F3_ADD, 5'd4, 5'd1, 5'd2));
    send_instr(enc_r(F7_SUB, F3_ADD, 5'd5, 5'd0, 5'd1));
    send_instr(enc_r(F7_BASE, F3_OR, 5'd6, 5'd2, 5'd1));
    send_instr(enc_r(F7_BASE, F3_AND, 5'd31, 5'd3, 5'd5));
  endtask

  task automatic test_illegal_encodings();
    send_instr(32'h0000_0000);
    send_instr(32'hFFFF_FFFF);
    send_instr(enc_r(7'b0000001, F3_ADD, 5'd7, 5'd1, 5'd2));
    send_instr(enc_r(F7_SUB, F3_OR, 5'd7, 5'd1, 5'd2));
  endtask

  task automatic test_memory_access();
    send_instr(enc_i(OP_IMM, F3_ADD, 5'd11, 5'd0, 12'd1020));
    // byte offset 15 truncates to three words: last data word
    send_instr(enc_s(F3_WORD, 5'd11, 5'd1, 12'd15));
    send_instr(enc_i(OP_LOAD, F3_WORD, 5'd12, 5'd11, 12'd12));
    send_instr(enc_s(F3_WORD, 5'd11, 5'd2, 12'd16));
    // -7 truncates to -1: negative address
    send_instr(enc_i(OP_LOAD, F3_WORD, 5'd13, 5'd0, 12'hFF9));
    send_instr(enc_i(OP_LOAD, F3_ADD, 5'd13, 5'd11, 12'd0));
  endtask

  task automatic test_branches();
    send_instr(enc_b(F3_BEQ, 5'd0, 5'd0, 13'd8));
    send_instr(enc_b(F3_BNE, 5'd1, 5'd1, 13'd8));
    send_instr(enc_b(F3_BLT, 5'd2, 5'd1, 13'h1000));
    send_instr(enc_b(F3_BNE, 5'd1, 5'd2, 13'd4094));
    send_instr(enc_b(F3_WORD, 5'd1, 5'd2, 13'd8));
  endtask

  task automatic test_jump_and_link();
    send_instr(enc_j(5'd15, 20'h7FFFF));
    send_instr(enc_j(5'd0, 20'h80000));
  endtask

  task automatic test_program_end();
    wait_for_idle();
    write_program_length(11'd1024);
    // target one past the last pc matches before the wrap
    jump_to_pc(PMEM_WORDS - 1, 5'd3);
    send_instr(enc_i(OP_IMM, F3_ADD, 5'd0, 5'd0, 12'd0));
    wait_for_idle();
    write_program_length(11'd7);
    jump_to_pc(7, 5'd0);
  endtask

  task automatic send_random_sequence();
    int          choice, v, k, dest;
    logic [4:0]  base, r1, r2;
    logic [11:0] off;
    logic [31:0] w;
    choice = $urandom_range(99);
    if (choice < 20) begin
      send_instr(enc_i(OP_IMM, pick_alu_f3(), pick_reg(), pick_reg(), 12'($urandom())));
    end else if (choice < 35) begin
      if ($urandom_range(3) == 0)
        send_instr(enc_r(F7_SUB, F3_ADD, pick_reg(), pick_reg(), pick_reg()));
      else
        send_instr(enc_r(F7_BASE, pick_alu_f3(), pick_reg(), pick_reg(), pick_reg()));
    end else if (choice < 50) begin
      base = 5'($urandom_range(1, 31));
      v = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1023);
      send_instr(enc_i(OP_IMM, F3_ADD, base, 5'd0, 12'(v)));
      if ($urandom_range(7) == 0) off = 12'($urandom());
      else begin
        v = $urandom_range(128);
        v = v - 64;
        off = 12'(v);
      end
      r1 = pick_reg();
      send_instr(enc_s(F3_WORD, base, r1, off));
      if ($urandom_range(9) == 0)
        send_instr(enc_i(OP_IMM, pick_alu_f3(), pick_reg(), pick_reg(), 12'($urandom())));
      send_instr(enc_i(OP_LOAD, F3_WORD, pick_reg(), base, off));
    end else if (choice < 62) begin
      case ($urandom_range(2))
        0: k = F3_BEQ;
        1: k = F3_BNE;
        default: k = F3_BLT;
      endcase
      r1 = pick_reg();
      r2 = $urandom_range(3) == 0 ? r1 : pick_reg();
      if ($urandom_range(4) == 0) v = $urandom();
      else begin
        v = $urandom_range(64);
        v = (v - 32) * 2;
      end
      send_instr(enc_b(funct3_t'(k), r1, r2, 13'(v)));
    end else if (choice < 70) begin
      if ($urandom_range(3) == 0) v = $urandom();
      else begin
        v = $urandom_range(80);
        v = v - 40;
      end
      send_instr(enc_j(pick_reg(), 20'(v)));
    end else if (choice < 76) begin
      dest = int'(plen_model) - $urandom_range(1);
      if (dest < 0) dest = dest + PMEM_WORDS;
      if (dest >= PMEM_WORDS) dest = dest - PMEM_WORDS;
      jump_to_pc(dest, pick_reg());
      send_instr(enc_i(OP_IMM, pick_alu_f3(), pick_reg(), pick_reg(), 12'($urandom())));
    end else if (choice < 84) begin
      base = pick_reg();
      k = $urandom_range(1, 8);
      repeat (k) send_instr(enc_r(F7_BASE, F3_ADD, base, base, base));
      if ($urandom_range(1)) send_instr(enc_r(F7_SUB, F3_ADD, base, 5'd0, base));
    end else if (choice < 92) begin
      send_instr($urandom());
    end else begin
      w = $urandom();
      case ($urandom_range(5))
        0: w[6:0] = OP_IMM;
        1: w[6:0] = OP_REG;
        2: w[6:0] = OP_BRANCH;
        3: w[6:0] = OP_LOAD;
        4: w[6:0] = OP_STORE;
        default: w[6:0] = OP_JAL;
      endcase
      send_instr(w);
    end
  endtask

  task automatic run_random_phase(input int n, input logic [PLEN_W-1:0] plen);
    int start;
    wait_for_idle();
    write_program_length(plen);
    start = items_sent;
    while (items_sent - start < n) send_random_sequence();
  endtask

  task automatic test_random_traffic();
    run_random_phase(400, 11'd1024);
    run_random_phase(400, 11'($urandom_range(1, 1023)));
    run_random_phase(300, 11'd0);
    run_random_phase(300, 11'd1);
  endtask

  task automatic test_back_to_back();
    idle_pct = 0;
    run_random_phase(300, 11'($urandom_range(1023)));
    idle_pct = 27;
  endtask

  initial begin
    pc_model = 0;
    plen_model = '0;
    foreach (regs_model[i]) regs_model[i] = '0;
    foreach (dmem_model[i]) dmem_model[i] = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_instruction <= '0;
    cfg_valid <= 1'b0;
    cfg_program_length <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_program_length(11'd0);
    test_immediate_ops();
    test_register_ops();
    test_illegal_encodings();
    test_memory_access();
    test_branches();
    test_jump_and_link();
    test_program_end();
    test_random_traffic();
    test_back_to_back();
    wait_for_idle();
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_steps.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
